// ===== rtl/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants of the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

   localparam int POOL_PAGES_DEF = 1024;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOSPACE = 2'd1;
   localparam logic [1:0] ST_BAD     = 2'd2;

   typedef struct packed {
      logic        kind;
      logic [9:0]  start_page;
      logic [10:0] page_count;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [9:0]  granted_page;
      logic [10:0] free_pages;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CLR,
      OP_LOAD,
      OP_SPLIT,
      OP_INS_RD,
      OP_MERGE,
      OP_INS_SET,
      OP_SRD,
      OP_SNEXT,
      OP_FOUND,
      OP_NOSPACE,
      OP_TAIL
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic req_bad;
      logic req_alloc;
      logic count_zero;
      logic ins_top;
      logic mark;
      logic scan_last;
      logic scan_top;
      logic tail_needed;
   } dp_stat_type;

endpackage

// ===== rtl/buddy_page_allocator.sv =====
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Buddy allocator over a pool of POOL_PAGES pages (a power of two).
//
// A transaction is taken when start is high and busy is low; req carries the
// kind (free or allocate), start page and page count. Exactly one result per
// transaction appears on rsp for one cycle with rsp_valid high; the receiver
// cannot stall it. busy stays high until the result has been shown, and the
// next transaction can be taken in the cycle after the result.
// A free splits its range into aligned pieces; each piece is inserted into the
// tree, merging with its buddy while the buddy is marked free, and then the
// result is shown. An allocate scans the free-mark tree one entry at a time
// from the rounded level upward; a found block is taken and any tail beyond
// the page count is freed as above. A bad request shows its result in the
// cycle after it is taken.
// After reset the free-mark memory is cleared, one entry per cycle, all
// 2*POOL_PAGES-1 entries, with busy high; the pool starts empty.
// ----------------------------------------------------------------------------
module buddy_page_allocator import bpa_pkg::*; #(
   parameter int POOL_PAGES = POOL_PAGES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req,
   output logic    rsp_valid,
   output rsp_type rsp
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   bpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   bpa_datapath #(
      .POOL_PAGES (POOL_PAGES)
   ) u_datapath (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .cmd   (cmd),
      .stat  (stat),
      .rsp   (rsp)
   );

endmodule

// ===== rtl/bpa_datapath.sv =====
// ----------------------------------------------------------------------------
// bpa_datapath
// Free-mark tree memory, working registers and free-page count.
// ----------------------------------------------------------------------------
module bpa_datapath import bpa_pkg::*; #(
   parameter int POOL_PAGES = POOL_PAGES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req,
   input  dp_cmd_type  cmd,
   output dp_stat_type stat,
   output rsp_type     rsp
);

   localparam int LEVELS = $clog2(POOL_PAGES);
   localparam int VW     = (LEVELS + 2 > 12) ? LEVELS + 2 : 12;
   localparam int LVW    = $clog2(LEVELS + 1);
   localparam int NW     = LEVELS + 1;
   localparam int MD     = 2 * POOL_PAGES - 1;
   localparam logic [VW-1:0]  PV  = VW'(POOL_PAGES);
   localparam logic [LVW-1:0] TOP = LVW'(LEVELS);
   localparam logic [NW-1:0]  MDL = NW'(MD - 1);
   localparam logic [VW-1:0]  TMAX = VW'(2047);

   logic mark_mem [MD];
   logic rd_ff;

   logic [VW-1:0]     start_ff, start_in, count_ff, count_in;
   logic [LVW-1:0]    lvl_ff, lvl_in;
   logic [LEVELS-1:0] blk_ff, blk_in;
   logic [10:0]       total_ff, total_in;
   logic [1:0]        status_ff, status_in;
   logic [9:0]        granted_ff, granted_in;
   logic [NW-1:0]     clr_ff, clr_in;

   logic [VW-1:0]  req_start, req_count, bsize, page, last_blk, step, tsum;
   logic [LVW-1:0] alloc_lvl, a_lvl, s_lvl, sp_lvl;
   logic [NW-1:0]  node_self, node_buddy, rd_addr, wr_addr;
   logic           wr_en, wr_data, bad;

   always_comb begin
      req_start = VW'(req.start_page);
      req_count = VW'(req.page_count);
      if (req.kind) begin
         bad = (req_count == '0) || (req_count > PV);
      end else begin
         bad = (req_count == '0) || (req_start + req_count > PV);
      end
      alloc_lvl = TOP;
      for (int l = LEVELS; l >= 0; l--) begin
         if ((VW'(1) << l) >= req_count) alloc_lvl = LVW'(l);
      end
      a_lvl = TOP;
      for (int l = LEVELS - 1; l >= 0; l--) begin
         if (start_ff[l]) a_lvl = LVW'(l);
      end
      s_lvl = '0;
      for (int l = 0; l <= LEVELS; l++) begin
         if ((VW'(1) << l) <= count_ff) s_lvl = LVW'(l);
      end
      sp_lvl = (a_lvl < s_lvl) ? a_lvl : s_lvl;
      step = VW'(1) << sp_lvl;
      bsize = VW'(1) << lvl_ff;
      page = VW'(blk_ff) << lvl_ff;
      last_blk = (PV >> lvl_ff) - VW'(1);
      node_self = NW'((PV >> lvl_ff) - VW'(1) + VW'(blk_ff));
      node_buddy = NW'((PV >> lvl_ff) - VW'(1) + VW'(blk_ff ^ LEVELS'(1)));
   end

   always_comb begin
      start_in   = start_ff;
      count_in   = count_ff;
      lvl_in     = lvl_ff;
      blk_in     = blk_ff;
      total_in   = total_ff;
      status_in  = status_ff;
      granted_in = granted_ff;
      clr_in     = clr_ff;
      wr_en      = 1'b0;
      wr_data    = 1'b0;
      wr_addr    = node_self;
      rd_addr    = node_self;
      tsum       = '0;
      case (cmd.op)
         OP_CLR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + NW'(1);
         end
         OP_LOAD: begin
            status_in  = bad ? ST_BAD : ST_OK;
            granted_in = '0;
            start_in   = req_start;
            count_in   = req_count;
            lvl_in     = alloc_lvl;
            blk_in     = '0;
            if (!bad && !req.kind) begin
               tsum     = VW'(total_ff) + req_count;
               total_in = (tsum > TMAX) ? 11'd2047 : tsum[10:0];
            end
         end
         OP_SPLIT: begin
            lvl_in   = sp_lvl;
            blk_in   = LEVELS'(start_ff >> sp_lvl);
            start_in = start_ff + step;
            count_in = count_ff - step;
         end
         OP_INS_RD: begin
            rd_addr = node_buddy;
         end
         OP_MERGE: begin
            wr_en   = 1'b1;
            wr_addr = node_buddy;
            blk_in  = blk_ff >> 1;
            lvl_in  = lvl_ff + LVW'(1);
         end
         OP_INS_SET: begin
            wr_en   = 1'b1;
            wr_data = 1'b1;
         end
         OP_SRD: begin
            rd_addr = node_self;
         end
         OP_SNEXT: begin
            if (VW'(blk_ff) == last_blk) begin
               blk_in = '0;
               lvl_in = lvl_ff + LVW'(1);
            end else begin
               blk_in = blk_ff + LEVELS'(1);
            end
         end
         OP_FOUND: begin
            wr_en      = 1'b1;
            granted_in = 10'(page);
            total_in   = (VW'(total_ff) > bsize) ? 11'(VW'(total_ff) - bsize) : '0;
            start_in   = page + count_ff;
            count_in   = bsize - count_ff;
         end
         OP_NOSPACE: begin
            status_in = ST_NOSPACE;
         end
         OP_TAIL: begin
            tsum     = VW'(total_ff) + count_ff;
            total_in = (tsum > TMAX) ? 11'd2047 : tsum[10:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mark_mem[wr_addr] <= wr_data;
      end
      rd_ff <= mark_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff   <= '0;
         total_ff <= '0;
      end else begin
         clr_ff   <= clr_in;
         total_ff <= total_in;
      end
      start_ff   <= start_in;
      count_ff   <= count_in;
      lvl_ff     <= lvl_in;
      blk_ff     <= blk_in;
      status_ff  <= status_in;
      granted_ff <= granted_in;
   end

   always_comb begin
      stat.clr_last    = (clr_ff == MDL);
      stat.req_bad     = bad;
      stat.req_alloc   = req.kind;
      stat.count_zero  = (count_ff == '0);
      stat.ins_top     = (lvl_ff == TOP);
      stat.mark        = rd_ff;
      stat.scan_last   = (VW'(blk_ff) == last_blk);
      stat.scan_top    = (lvl_ff == TOP);
      stat.tail_needed = (bsize > count_ff);
      rsp.status       = status_ff;
      rsp.granted_page = granted_ff;
      rsp.free_pages   = total_ff;
   end

`ifndef SYNTH
   a_tail_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_TAIL |=> total_ff >= $past(total_ff)) else $error("total shrank");
   a_found_shrinks: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_FOUND |=> total_ff <= $past(total_ff)) else $error("total grew");
   a_merge_up: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_MERGE |=> lvl_ff == $past(lvl_ff) + LVW'(1)) else $error("bad merge");
`endif

endmodule

// ===== rtl/bpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer for clearing, splitting, merging and block search.
// ----------------------------------------------------------------------------
module bpa_ctrl import bpa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd,
   output logic        busy,
   output logic        rsp_valid
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_SPLIT, S_INS_RD, S_INS_CHK, S_SRD, S_SCHK, S_TAIL, S_DONE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      case (state_ff)
         S_CLEAR: begin
            cmd.op = OP_CLR;
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.op = OP_LOAD;
               if (stat.req_bad) state_in = S_DONE;
               else if (stat.req_alloc) state_in = S_SRD;
               else state_in = S_SPLIT;
            end
         end
         S_SPLIT: begin
            if (stat.count_zero) begin
               state_in = S_DONE;
            end else begin
               cmd.op   = OP_SPLIT;
               state_in = S_INS_RD;
            end
         end
         S_INS_RD: begin
            if (stat.ins_top) begin
               cmd.op   = OP_INS_SET;
               state_in = S_SPLIT;
            end else begin
               cmd.op   = OP_INS_RD;
               state_in = S_INS_CHK;
            end
         end
         S_INS_CHK: begin
            if (stat.mark) begin
               cmd.op   = OP_MERGE;
               state_in = S_INS_RD;
            end else begin
               cmd.op   = OP_INS_SET;
               state_in = S_SPLIT;
            end
         end
         S_SRD: begin
            cmd.op   = OP_SRD;
            state_in = S_SCHK;
         end
         S_SCHK: begin
            if (stat.mark) begin
               cmd.op   = OP_FOUND;
               state_in = stat.tail_needed ? S_TAIL : S_DONE;
            end else if (stat.scan_last && stat.scan_top) begin
               cmd.op   = OP_NOSPACE;
               state_in = S_DONE;
            end else begin
               cmd.op   = OP_SNEXT;
               state_in = S_SRD;
            end
         end
         S_TAIL: begin
            cmd.op   = OP_TAIL;
            state_in = S_SPLIT;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);

endmodule

// ===== tb/sv/tb_buddy_page_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_buddy_page_allocator
// Self-checking bench for the buddy page allocator. Directed tests cover bad
// requests, freeing and merging, allocation with tail return and no-space
// cases. A random phase runs alloc/free sequences with some noise. Every
// result is compared against an in-bench model of the free-mark tree.
// ----------------------------------------------------------------------------
module tb_buddy_page_allocator;
   import bpa_pkg::*;

   localparam int POOL      = 1024;
   localparam int TOP_LVL   = 10;
   localparam int MARKS     = 2 * POOL - 1;
   localparam int TOTAL_CAP = 2047;
   localparam int WD_LIMIT  = 30000;
   localparam logic KIND_FREE  = 1'b0;
   localparam logic KIND_ALLOC = 1'b1;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req;
   logic    rsp_valid;
   rsp_type rsp;

   bit          free_map [MARKS];
   int unsigned free_total;
   rsp_type     pending_rsp [$];
   int          held_page [$];
   int          held_count [$];
   int          mismatches;
   int          items_sent;
   int          results_seen;
   int          idle_cycles;
   bit          no_gaps;

   buddy_page_allocator #(.POOL_PAGES(POOL)) DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req(req), .rsp_valid(rsp_valid), .rsp(rsp)
   );

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   function automatic int unsigned node_idx(int lvl, int unsigned b);
      int unsigned idx;
      idx = (POOL >> lvl) - 1 + b;
      return (idx < MARKS) ? idx : 0;
   endfunction

   function automatic void merge_in(int unsigned page, int lvl);
      int unsigned b;
      b = page >> lvl;
      while (lvl < TOP_LVL) begin
         if ((b ^ 1) < (POOL >> lvl) && free_map[node_idx(lvl, b ^ 1)]) begin
            free_map[node_idx(lvl, b ^ 1)] = 1'b0;
            b = b >> 1;
            lvl++;
         end else begin
            break;
         end
      end
      if (b < (POOL >> lvl)) free_map[node_idx(lvl, b)] = 1'b1;
   endfunction

   function automatic void return_region(int unsigned pg, int unsigned cnt);
      int al, sz, lvl;
      free_total += cnt;
      if (free_total > TOTAL_CAP) free_total = TOTAL_CAP;
      while (cnt > 0) begin
         al = TOP_LVL;
         sz = 0;
         if (pg != 0) begin
            al = 0;
            while (al < TOP_LVL && ((pg >> al) & 1) == 0) al++;
         end
         while (sz < TOP_LVL && (1 << (sz + 1)) <= cnt) sz++;
         lvl = (al < sz) ? al : sz;
         merge_in(pg, lvl);
         pg  += (1 << lvl);
         cnt -= (1 << lvl);
      end
   endfunction

   function automatic rsp_type predict_alloc(req_type r);
      rsp_type     res;
      int unsigned cnt, bsize, page, b;
      int          lvl, l;
      bit          found;
      cnt = r.page_count;
      res = '0;
      res.status = ST_OK;
      found = 1'b0;
      b = 0;
      if (r.kind == KIND_FREE) begin
         if (cnt == 0 || r.start_page + cnt > POOL) res.status = ST_BAD;
         else return_region(r.start_page, cnt);
      end else if (cnt == 0 || cnt > POOL) begin
         res.status = ST_BAD;
      end else begin
         lvl = 0;
         while (lvl < TOP_LVL && (1 << lvl) < cnt) lvl++;
         for (l = lvl; l <= TOP_LVL && !found; l++) begin
            for (b = 0; b < (POOL >> l); b++)
               if (free_map[node_idx(l, b)]) begin
                  found = 1'b1;
                  break;
               end
            if (found) break;
         end
         if (!found) begin
            res.status = ST_NOSPACE;
         end else begin
            bsize = 1 << l;
            page  = b << l;
            free_map[node_idx(l, b)] = 1'b0;
            free_total = (free_total > bsize) ? free_total - bsize : 0;
            if (bsize > cnt) return_region(page + cnt, bsize - cnt);
            res.granted_page = page[9:0];
         end
      end
      res.free_pages = free_total[10:0];
      return res;
   endfunction

   // drives one transaction; start stays high across back-to-back items
   task automatic send_item(logic kind, int unsigned pg, int unsigned cnt);
      int      gap;
      bit      ready;
      req_type r;
      rsp_type res;
      r.kind = kind;
      r.start_page = pg[9:0];
      r.page_count = cnt[10:0];
      gap = no_gaps ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req   <= r;
      forever begin
         @(negedge clock);
         ready = !busy;
         @(posedge clock);
         if (ready) break;
      end
      res = predict_alloc(r);
      pending_rsp.push_back(res);
      items_sent++;
      idle_cycles = 0;
      if (kind == KIND_ALLOC && res.status == ST_OK) begin
         held_page.push_back(res.granted_page);
         held_count.push_back(cnt);
      end
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (pending_rsp.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic release_held(int idx);
      int pg, cnt;
      pg  = held_page[idx];
      cnt = held_count[idx];
      held_page.delete(idx);
      held_count.delete(idx);
      send_item(KIND_FREE, pg, cnt);
   endtask

   task automatic test_bad_requests();
      send_item(KIND_FREE, 0, 0);
      send_item(KIND_ALLOC, 0, 0);
      send_item(KIND_ALLOC, 0, 1025);
      send_item(KIND_ALLOC, 0, 2047);
      send_item(KIND_FREE, 1023, 2);
      send_item(KIND_FREE, 1, 1024);
      send_item(KIND_ALLOC, 0, 1);
   endtask

   task automatic test_free_and_merge();
      send_item(KIND_FREE, 3, 5);
      send_item(KIND_FREE, 0, 3);
      send_item(KIND_FREE, 8, 1016);
      send_item(KIND_FREE, 1023, 1);
      send_item(KIND_FREE, 0, 1024);
   endtask

   task automatic test_alloc_tail();
      send_item(KIND_ALLOC, 0, 1024);
      send_item(KIND_ALLOC, 0, 1);
      send_item(KIND_FREE, 0, 1024);
      send_item(KIND_ALLOC, 0, 3);
      send_item(KIND_ALLOC, 0, 1000);
      send_item(KIND_ALLOC, 0, 513);
      send_item(KIND_ALLOC, 0, 1);
      send_item(KIND_ALLOC, 0, 16);
      drain_results();
      while (held_page.size() > 0) release_held(0);
   endtask

   task automatic test_random(int n);
      int          k, sel;
      int unsigned cnt, pg;
      for (k = 0; k < n; k++) begin
         if (k % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
         sel = $urandom_range(0, 99);
         if (sel < 45) begin
            cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 1024)
                                              : $urandom_range(1, 40);
            send_item(KIND_ALLOC, $urandom_range(0, 1023), cnt);
         end else if (sel < 85 && held_page.size() > 0) begin
            release_held($urandom_range(0, held_page.size() - 1));
         end else if (sel < 92) begin
            pg = $urandom_range(0, 1023);
            send_item(KIND_FREE, pg, $urandom_range(1, 1024 - pg));
         end else begin
            send_item(1'($urandom_range(0, 1)), $urandom_range(0, 1023),
                      $urandom_range(0, 2047));
         end
      end
      no_gaps = 1'b0;
   endtask

   always @(negedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         idle_cycles = 0;
         results_seen++;
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result %p", $time, rsp);
            mismatches++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp.status !== want.status)
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp.status);
            if (rsp.granted_page !== want.granted_page)
               $display("%0t: granted_page expected %0d actual %0d",
                        $time, want.granted_page, rsp.granted_page);
            if (rsp.free_pages !== want.free_pages)
               $display("%0t: free_pages expected %0d actual %0d",
                        $time, want.free_pages, rsp.free_pages);
            if (rsp !== want) mismatches++;
         end
      end
   end

   always @(posedge clock) begin
      idle_cycles++;
      if (idle_cycles >= WD_LIMIT) begin
         $display("%0t: watchdog expired", $time);
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      mismatches = 0;
      items_sent = 0;
      results_seen = 0;
      idle_cycles = 0;
      no_gaps = 1'b0;
      free_total = 0;
      foreach (free_map[i]) free_map[i] = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req   = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_bad_requests();
      test_free_and_merge();
      drain_results();
      test_alloc_tail();
      test_random(500);
      drain_results();
      test_random(500);
      drain_results();
      $display("Covered %0d transactions, %0d results: bad requests, merges,",
               items_sent, results_seen);
      $display("tail splits, no-space allocates and random alloc/free traffic.");
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/bpa_pkg.sv
rtl/bpa_datapath.sv
rtl/bpa_ctrl.sv
rtl/buddy_page_allocator.sv
tb/sv/tb_buddy_page_allocator.sv
